[src/i2cm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Shared widths, operation codes and sequencer phase codes.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   localparam int UNIT_W  = 8;
   localparam int DELAY_W = 10;
   localparam int BYTE_W  = 8;
   localparam int BITC_W  = 4;

   // Reset value of the timing unit register.
   localparam logic [UNIT_W-1:0] UNIT_TICKS_RESET = 8'h01;

   typedef enum logic [2:0] {
      OP_START        = 3'd0,
      OP_RSTART       = 3'd1,
      OP_STOP         = 3'd2,
      OP_WRITE        = 3'd3,
      OP_READ_ACK     = 3'd4,
      OP_READ_NACK    = 3'd5,
      OP_WRITE_NACKED = 3'd6
   } op_type;

   typedef enum logic [4:0] {
      PH_IDLE   = 5'd0,
      PH_ST_A   = 5'd1,
      PH_ST_B   = 5'd2,
      PH_ST_C   = 5'd3,
      PH_RS_A   = 5'd4,
      PH_RS_B   = 5'd5,
      PH_RS_C   = 5'd6,
      PH_RS_D   = 5'd7,
      PH_RS_E   = 5'd8,
      PH_RS_F   = 5'd9,
      PH_RS_G   = 5'd10,
      PH_SP_A   = 5'd11,
      PH_SP_B   = 5'd12,
      PH_CK_LO1 = 5'd13,
      PH_CK_HI  = 5'd14,
      PH_CK_LO2 = 5'd15,
      PH_AK_A   = 5'd16,
      PH_AK_B   = 5'd17,
      PH_AK_C   = 5'd18,
      PH_AK_D   = 5'd19
   } phase_type;

endpackage

[src/i2cm_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte engine channel interfaces
// Tick request channel, bus result channel and timing register write channel.
// ----------------------------------------------------------------------------
interface i2cm_req_if;
   import i2cm_pkg::*;
   logic              valid;
   logic              ready;
   logic              cmd_valid;
   logic [2:0]        op;
   logic [BYTE_W-1:0] tx_byte;
   logic              sda_in;

   modport source (output valid, cmd_valid, op, tx_byte, sda_in, input ready);
   modport sink   (input valid, cmd_valid, op, tx_byte, sda_in, output ready);
endinterface

interface i2cm_rsp_if;
   import i2cm_pkg::*;
   logic              valid;
   logic              ready;
   logic              scl_level;
   logic              sda_release;
   logic              busy_res;
   logic              cmd_done;
   logic [BYTE_W-1:0] rx_byte;
   logic              ack_error;

   modport source (output valid, scl_level, sda_release, busy_res, cmd_done,
                   rx_byte, ack_error, input ready);
   modport sink   (input valid, scl_level, sda_release, busy_res, cmd_done,
                   rx_byte, ack_error, output ready);
endinterface

interface i2cm_csr_if;
   import i2cm_pkg::*;
   logic              valid;
   logic              ready;
   logic [UNIT_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

[src/i2c_master_byte_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte engine
// Tick-driven I2C bus master: start, repeated start, stop, byte write with
// ACK check and automatic stop on NACK, byte read with ACK or NACK.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Word carried
//   ---------  ---------  ---------------------------------------------------
//   req_chan   in         one bus tick: optional command, byte, sampled SDA
//   rsp_chan   out        SCL/SDA drive, busy, done, received byte, ACK error
//   csr_chan   in         ticks per 5 us timing unit (write only)
//
// Every accepted request word is one tick of the bus sequencer and produces
// exactly one response word. The whole update is one pass of combinational
// logic from the state registers and the request word into the state and the
// response register, so a word is taken in every cycle while no response is stalled.
// The response register frees the request side: a new word is accepted while
// the previous response is still held, provided it is taken in the same cycle.
// Reset is synchronous and active high; it idles the sequencer, releases both
// bus lines and sets the timing unit to one tick.
//
module i2c_master_byte_engine (
   input  logic       clock,
   input  logic       reset,
   i2cm_req_if.sink   req_chan,
   i2cm_rsp_if.source rsp_chan,
   i2cm_csr_if.sink   csr_chan
);
   import i2cm_pkg::*;

   // Sequencer state.
   phase_type          phase_ff, phase_in;
   logic [BITC_W-1:0]  bit_count_ff, bit_count_in;
   logic [BYTE_W-1:0]  shift_reg_ff, shift_reg_in;
   logic [DELAY_W-1:0] delay_count_ff, delay_count_in;
   op_type             current_op_ff, current_op_in;
   logic               scl_reg_ff, scl_reg_in;
   logic               sda_reg_ff, sda_reg_in;
   logic [UNIT_W-1:0]  unit_ticks_ff;

   // Result of this tick.
   logic               done;

   // Response register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_scl_ff, rsp_sda_ff, rsp_busy_ff, rsp_done_ff, rsp_err_ff;
   logic [BYTE_W-1:0]  rsp_rx_ff;
   logic               rsp_busy_in, rsp_err_in;
   logic [BYTE_W-1:0]  rsp_rx_in;

   logic               req_fire;
   logic [UNIT_W-1:0]  unit_eff;
   logic [DELAY_W-1:0] dly1, dly2, dly4, dly_dec;
   logic               is_read;
   logic [BITC_W-1:0]  bit_count_inc;
   op_type             req_op;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_op         = op_type'(req_chan.op);

   // A zero timing unit behaves as one tick. Every wait is 1, 2 or 4 units,
   // so the wait lengths are plain shifts of the unit.
   assign unit_eff = (unit_ticks_ff == '0) ? UNIT_W'(1) : unit_ticks_ff;
   assign dly1     = DELAY_W'(unit_eff);
   assign dly2     = DELAY_W'({unit_eff, 1'b0});
   assign dly4     = DELAY_W'({unit_eff, 2'b00});
   assign dly_dec  = (delay_count_ff != '0) ? delay_count_ff - DELAY_W'(1)
                                            : delay_count_ff;

   assign is_read       = (current_op_ff == OP_READ_ACK) || (current_op_ff == OP_READ_NACK);
   assign bit_count_inc = bit_count_ff + BITC_W'(1);

   // Next-state logic: command start when idle, otherwise count the wait down
   // and take the next bus step when it runs out.
   always_comb begin
      phase_in       = phase_ff;
      bit_count_in   = bit_count_ff;
      shift_reg_in   = shift_reg_ff;
      delay_count_in = delay_count_ff;
      current_op_in  = current_op_ff;
      scl_reg_in     = scl_reg_ff;
      sda_reg_in     = sda_reg_ff;
      done           = 1'b0;

      if (phase_ff == PH_IDLE) begin
         if (req_chan.cmd_valid && (req_op <= OP_READ_NACK)) begin
            current_op_in = req_op;
            case (req_op)
               OP_START: begin
                  sda_reg_in = 1'b1;
                  scl_reg_in = 1'b1;
                  phase_in = PH_ST_A;
                  delay_count_in = dly4;
               end
               OP_RSTART: begin
                  phase_in = PH_RS_A;
                  delay_count_in = dly4;
               end
               OP_STOP: begin
                  sda_reg_in = 1'b0;
                  phase_in = PH_SP_A;
                  delay_count_in = dly2;
               end
               OP_WRITE: begin
                  shift_reg_in = req_chan.tx_byte;
                  bit_count_in = '0;
                  sda_reg_in = req_chan.tx_byte[BYTE_W-1];
                  phase_in = PH_CK_LO1;
                  delay_count_in = dly1;
               end
               default: begin
                  // Both reads start with SDA released and an empty shifter.
                  shift_reg_in = '0;
                  bit_count_in = '0;
                  sda_reg_in = 1'b1;
                  phase_in = PH_CK_LO1;
                  delay_count_in = dly1;
               end
            endcase
         end
      end else begin
         delay_count_in = dly_dec;
         if (dly_dec == '0) begin
            case (phase_ff)
               PH_ST_A: begin
                  sda_reg_in = 1'b0;
                  phase_in = PH_ST_B;
                  delay_count_in = dly2;
               end
               PH_ST_B: begin
                  scl_reg_in = 1'b0;
                  phase_in = PH_ST_C;
                  delay_count_in = dly2;
               end
               PH_RS_A: begin
                  phase_in = PH_RS_B;
                  delay_count_in = dly4;
               end
               PH_RS_B: begin
                  sda_reg_in = 1'b1;
                  phase_in = PH_RS_C;
                  delay_count_in = dly2;
               end
               PH_RS_C: begin
                  scl_reg_in = 1'b1;
                  phase_in = PH_RS_D;
                  delay_count_in = dly4;
               end
               PH_RS_D: begin
                  phase_in = PH_RS_E;
                  delay_count_in = dly4;
               end
               PH_RS_E: begin
                  sda_reg_in = 1'b0;
                  phase_in = PH_RS_F;
                  delay_count_in = dly2;
               end
               PH_RS_F: begin
                  scl_reg_in = 1'b0;
                  phase_in = PH_RS_G;
                  delay_count_in = dly2;
               end
               PH_SP_A: begin
                  scl_reg_in = 1'b1;
                  phase_in = PH_SP_B;
                  delay_count_in = dly2;
               end
               PH_SP_B: begin
                  sda_reg_in = 1'b1;
                  done = 1'b1;
               end
               PH_CK_LO1: begin
                  // Read data is sampled as SCL is released.
                  if (is_read && (bit_count_ff < BITC_W'(8))) begin
                     shift_reg_in = {shift_reg_ff[BYTE_W-2:0], req_chan.sda_in};
                  end
                  scl_reg_in = 1'b1;
                  phase_in = PH_CK_HI;
                  delay_count_in = dly2;
               end
               PH_CK_HI: begin
                  scl_reg_in = 1'b0;
                  phase_in = PH_CK_LO2;
                  delay_count_in = dly1;
               end
               PH_CK_LO2: begin
                  bit_count_in = bit_count_inc;
                  if (!is_read) begin
                     if (bit_count_inc < BITC_W'(8)) begin
                        shift_reg_in = {shift_reg_ff[BYTE_W-2:0], 1'b0};
                        sda_reg_in = shift_reg_ff[BYTE_W-2];
                        phase_in = PH_CK_LO1;
                        delay_count_in = dly1;
                     end else begin
                        sda_reg_in = 1'b1;
                        phase_in = PH_AK_A;
                        delay_count_in = dly1;
                     end
                  end else if (bit_count_inc < BITC_W'(8)) begin
                     phase_in = PH_CK_LO1;
                     delay_count_in = dly1;
                  end else if (bit_count_inc == BITC_W'(8)) begin
                     // Ninth clock: drive ACK low, or leave SDA released for NACK.
                     sda_reg_in = (current_op_ff == OP_READ_NACK);
                     phase_in = PH_CK_LO1;
                     delay_count_in = dly1;
                  end else begin
                     if (current_op_ff == OP_READ_NACK) begin
                        sda_reg_in = 1'b0;
                     end
                     done = 1'b1;
                  end
               end
               PH_AK_A: begin
                  scl_reg_in = 1'b1;
                  phase_in = PH_AK_B;
                  delay_count_in = dly1;
               end
               PH_AK_B: begin
                  // SDA still high while SCL is high means the slave refused the byte.
                  if (req_chan.sda_in) begin
                     current_op_in = OP_WRITE_NACKED;
                  end
                  phase_in = PH_AK_C;
                  delay_count_in = dly1;
               end
               PH_AK_C: begin
                  scl_reg_in = 1'b0;
                  phase_in = PH_AK_D;
                  delay_count_in = dly1;
               end
               PH_AK_D: begin
                  sda_reg_in = 1'b0;
                  if (current_op_ff == OP_WRITE_NACKED) begin
                     phase_in = PH_SP_A;
                     delay_count_in = dly2;
                  end else begin
                     done = 1'b1;
                  end
               end
               default: begin
                  // End of the last hold of a start or repeated start.
                  done = 1'b1;
               end
            endcase
            if (done) begin
               phase_in = PH_IDLE;
               delay_count_in = '0;
            end
         end
      end
   end

   // Output logic: response word for this tick.
   always_comb begin
      rsp_busy_in  = (phase_in != PH_IDLE);
      rsp_rx_in    = (done && is_read) ? shift_reg_in : '0;
      rsp_err_in   = done && (current_op_ff == OP_WRITE_NACKED);
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         bit_count_ff   <= '0;
         shift_reg_ff   <= '0;
         delay_count_ff <= '0;
         current_op_ff  <= OP_START;
         scl_reg_ff     <= 1'b1;
         sda_reg_ff     <= 1'b1;
         unit_ticks_ff  <= UNIT_TICKS_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid) begin
            unit_ticks_ff <= csr_chan.data;
         end
         if (req_fire) begin
            phase_ff       <= phase_in;
            bit_count_ff   <= bit_count_in;
            shift_reg_ff   <= shift_reg_in;
            delay_count_ff <= delay_count_in;
            current_op_ff  <= current_op_in;
            scl_reg_ff     <= scl_reg_in;
            sda_reg_ff     <= sda_reg_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_scl_ff  <= scl_reg_in;
         rsp_sda_ff  <= sda_reg_in;
         rsp_busy_ff <= rsp_busy_in;
         rsp_done_ff <= done;
         rsp_rx_ff   <= rsp_rx_in;
         rsp_err_ff  <= rsp_err_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.scl_level   = rsp_scl_ff;
   assign rsp_chan.sda_release = rsp_sda_ff;
   assign rsp_chan.busy_res    = rsp_busy_ff;
   assign rsp_chan.cmd_done    = rsp_done_ff;
   assign rsp_chan.rx_byte     = rsp_rx_ff;
   assign rsp_chan.ack_error   = rsp_err_ff;

endmodule
